[rtl/assert_macros.svh]
// Assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset
`define CHK_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("port check failed");

// Next-cycle implication, quiet during reset
`define CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

[rtl/pmht_pkg.sv]
package pmht_pkg;

   // residues of the level primes, all below 32
   localparam int PRIME_COUNT = 10;
   localparam int RES_W       = 5;
   localparam int LVL_W       = 4;
   localparam int KEY_W       = 32;
   localparam int NIB_STEPS   = KEY_W / 4;

   localparam logic [RES_W-1:0] PRIME_TABLE [PRIME_COUNT] =
      '{5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29};

   // opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // status codes
   localparam logic [2:0] ST_INSERTED    = 3'd0;
   localparam logic [2:0] ST_FOUND       = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
   localparam logic [2:0] ST_DELETED     = 3'd3;
   localparam logic [2:0] ST_DEL_MISSING = 3'd4;
   localparam logic [2:0] ST_ERROR       = 3'd5;

   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] key;
      logic [31:0]      data;
   } node_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_EVAL
   } state_type;

   typedef logic [RES_W-1:0] res_arr_type [PRIME_COUNT];

   // one nibble of (r*16 + nib) mod p, with r < p
   function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0] r,
                                                 input logic [3:0] nib,
                                                 input logic [RES_W-1:0] p);
      logic [RES_W+3:0] v;
      logic [RES_W+3:0] sub;
      v = {r, nib};
      for (int k = 3; k >= 0; k--) begin
         sub = {4'd0, p} << k;
         if (v >= sub) v = v - sub;
      end
      return v[RES_W-1:0];
   endfunction

endpackage

[rtl/prime_modulus_hash_tree_top.sv]
// Prime-modulus hash tree. Pulse start with an insert, find or delete item while busy
// is low; exactly one result comes back later on rsp_status / rsp_found_value, marked
// by rsp_valid for a single cycle, and cannot be held off. After reset the block sweeps
// its memories and keeps busy high until the sweep ends. An item is then handled in
// steps: nibble-serial residue computation (8 nibble steps, then a done step), then a
// read and an evaluate step of the node and link memories per tree level visited (1 to
// MAX_LEVELS+1 levels, none for the unused opcode), then the result strobe. The next
// item may start in the cycle of the strobe.
module prime_modulus_hash_tree_top import pmht_pkg::*; #(
   parameter int NODE_COUNT  = 1024,
   parameter int CHILD_SLOTS = 32,
   parameter int MAX_LEVELS  = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_found_value
);

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int ROW_W  = CHILD_SLOTS * NODE_W;

   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [31:0]       key_ff, key_in;
   logic [31:0]       val_ff, val_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [NODE_W:0]   alloc_ff, alloc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;

   logic              accept, clearing, res_done;
   res_arr_type       res;
   node_type          rd_node, node_wd;
   logic [ROW_W-1:0]  rd_row, row_wd;
   logic              node_we, row_we;
   logic [RES_W-1:0]  slot;
   logic [NODE_W-1:0] next_node;
   logic              match, at_bottom, finish;

   assign accept = start && (state_ff == S_IDLE);

   pmht_residue u_res (
      .clock (clock), .reset (reset), .go (accept), .key (req_key),
      .done (res_done), .res (res)
   );

   pmht_store #(.NODE_COUNT (NODE_COUNT), .CHILD_SLOTS (CHILD_SLOTS)) u_store (
      .clock (clock), .reset (reset), .clearing (clearing),
      .rd_addr (node_ff), .rd_node (rd_node), .rd_row (rd_row),
      .node_we (node_we), .node_wa (node_ff), .node_wd (node_wd),
      .row_we (row_we), .row_wa (node_ff), .row_wd (row_wd)
   );

   // level decode
   assign slot      = res[lvl_ff];
   assign next_node = rd_row[slot * NODE_W +: NODE_W];
   assign match     = rd_node.used && (rd_node.key == key_ff);
   assign at_bottom = (lvl_ff >= LVL_W'(MAX_LEVELS));

   // evaluate one level: writes, result and descent
   always_comb begin
      node_we       = 1'b0;
      node_wd       = rd_node;
      row_we        = 1'b0;
      row_wd        = rd_row;
      finish        = 1'b0;
      node_in       = node_ff;
      lvl_in        = lvl_ff;
      alloc_in      = alloc_ff;
      rsp_status_in = ST_NOT_FOUND;
      rsp_value_in  = '0;
      if (state_ff == S_EVAL) begin
         if (op_ff == OP_INSERT) begin
            if (!rd_node.used) begin
               node_we       = 1'b1;
               node_wd       = '{used: 1'b1, key: key_ff, data: val_ff};
               finish        = 1'b1;
               rsp_status_in = ST_INSERTED;
            end else if (at_bottom) begin
               finish        = 1'b1;
               rsp_status_in = ST_ERROR;
            end else if (next_node != '0) begin
               node_in = next_node;
               lvl_in  = lvl_ff + 1'b1;
            end else if (alloc_ff >= (NODE_W+1)'(NODE_COUNT)) begin
               finish        = 1'b1;
               rsp_status_in = ST_ERROR;
            end else begin
               // new nodes are still clean from the sweep
               row_we = 1'b1;
               row_wd[slot * NODE_W +: NODE_W] = alloc_ff[NODE_W-1:0];
               node_in  = alloc_ff[NODE_W-1:0];
               lvl_in   = lvl_ff + 1'b1;
               alloc_in = alloc_ff + 1'b1;
            end
         end else begin
            if (match) begin
               finish = 1'b1;
               if (op_ff == OP_FIND) begin
                  rsp_status_in = ST_FOUND;
                  rsp_value_in  = rd_node.data;
               end else begin
                  node_we       = 1'b1;
                  node_wd.used  = 1'b0;
                  rsp_status_in = ST_DELETED;
               end
            end else if (at_bottom || next_node == '0) begin
               finish        = 1'b1;
               rsp_status_in = (op_ff == OP_FIND) ? ST_NOT_FOUND : ST_DEL_MISSING;
            end else begin
               node_in = next_node;
               lvl_in  = lvl_ff + 1'b1;
            end
         end
      end else if (state_ff == S_HASH && res_done && op_ff == OP_UNUSED) begin
         // unused opcode: nothing walked
         finish = 1'b1;
      end
      if (accept) begin
         node_in = '0;
         lvl_in  = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (!clearing) state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_HASH;
         S_HASH:  if (res_done) state_in = finish ? S_IDLE : S_READ;
         S_READ:  state_in = S_EVAL;
         S_EVAL:  state_in = finish ? S_IDLE : S_READ;
         default: state_in = S_IDLE;
      endcase
   end

   // request capture and result strobe
   always_comb begin
      op_in        = accept ? req_opcode : op_ff;
      key_in       = accept ? req_key : key_ff;
      val_in       = accept ? req_value : val_ff;
      rsp_valid_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         alloc_ff     <= (NODE_W+1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      node_ff       <= node_in;
      lvl_ff        <= lvl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

[rtl/pmht_residue.sv]
// key modulo every level prime, one nibble per cycle, all primes in parallel
module pmht_residue import pmht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output res_arr_type      res
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   res_arr_type      res_ff, res_in;

   // step control
   always_comb begin
      key_in  = key_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (go) begin
         key_in = key;
         cnt_in = '0;
         run_in = 1'b1;
         for (int i = 0; i < PRIME_COUNT; i++) res_in[i] = '0;
      end else if (run_ff) begin
         key_in = key_ff << 4;
         cnt_in = cnt_ff + 3'd1;
         for (int i = 0; i < PRIME_COUNT; i++)
            res_in[i] = mod_step(res_ff[i], key_ff[KEY_W-1 -: 4], PRIME_TABLE[i]);
         if (cnt_ff == 3'(NIB_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      key_ff <= key_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

[rtl/pmht_store.sv]
// node memory and child link memory (one row of links per node), cleared after reset
module pmht_store import pmht_pkg::*; #(
   parameter int NODE_COUNT  = 1024,
   parameter int CHILD_SLOTS = 32,
   parameter int NODE_W      = $clog2(NODE_COUNT),
   parameter int ROW_W       = CHILD_SLOTS * NODE_W
) (
   input  logic              clock,
   input  logic              reset,
   output logic              clearing,
   input  logic [NODE_W-1:0] rd_addr,
   output node_type          rd_node,
   output logic [ROW_W-1:0]  rd_row,
   input  logic              node_we,
   input  logic [NODE_W-1:0] node_wa,
   input  node_type          node_wd,
   input  logic              row_we,
   input  logic [NODE_W-1:0] row_wa,
   input  logic [ROW_W-1:0]  row_wd
);

   node_type          node_mem [NODE_COUNT];
   logic [ROW_W-1:0]  link_mem [NODE_COUNT];

   logic              clr_ff, clr_in;
   logic [NODE_W-1:0] clr_cnt_ff, clr_cnt_in;
   node_type          node_rd_ff;
   logic [ROW_W-1:0]  row_rd_ff;

   // clearing sweep, one node a cycle
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == NODE_W'(NODE_COUNT - 1)) clr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // node memory
   always_ff @(posedge clock) begin
      if (clr_ff) node_mem[clr_cnt_ff] <= '0;
      else if (node_we) node_mem[node_wa] <= node_wd;
      node_rd_ff <= node_mem[rd_addr];
   end

   // link memory
   always_ff @(posedge clock) begin
      if (clr_ff) link_mem[clr_cnt_ff] <= '0;
      else if (row_we) link_mem[row_wa] <= row_wd;
      row_rd_ff <= link_mem[rd_addr];
   end

   assign clearing = clr_ff;
   assign rd_node  = node_rd_ff;
   assign rd_row   = row_rd_ff;

endmodule

[rtl/pmht_checker.sv]
`include "assert_macros.svh"

// port-level checks on the hash tree
module pmht_checker import pmht_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_found_value
);

   // an accepted item keeps the block busy until its result
   `CHK_NEXT(a_accept_busy, start && !busy, busy)
   // a result ends the item, so the block is free when it shows
   `CHK_SAME(a_rsp_idle, rsp_valid, !busy)
   // only a hit carries a value
   `CHK_SAME(a_value_zero, rsp_valid && rsp_status != ST_FOUND, rsp_found_value == 32'd0)
   // status is always a defined code
   `CHK_SAME(a_status_code, rsp_valid, rsp_status <= ST_ERROR)

endmodule

bind prime_modulus_hash_tree_top pmht_checker u_pmht_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found_value (rsp_found_value)
);

[tb/sv/tb_prime_modulus_hash_tree_top.sv]
`timescale 1ns / 1ps

module tb_prime_modulus_hash_tree_top;
   import pmht_pkg::*;

   localparam int NODES      = 1024;
   localparam int SLOTS      = 32;
   localparam int LEVELS     = 10;
   localparam int CYCLE_CAP  = 2000000;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] value;
   } outcome_type;

   // hash tree predictor and queue of pending outcomes
   class tree_scoreboard;
      bit          used [NODES];
      logic [31:0] key_mem [NODES];
      logic [31:0] data_mem [NODES];
      int unsigned link_mem [NODES*SLOTS];
      int unsigned alloc_count;
      outcome_type pending [$];
      int          fails;
      int          seen;
      int          per_status [8];

      function void clear_tree();
         foreach (used[i]) used[i] = 0;
         foreach (link_mem[i]) link_mem[i] = 0;
         alloc_count = 1;
      endfunction

      function logic [2:0] tree_insert(logic [31:0] key, logic [31:0] val);
         int unsigned node, lvl, slot, nxt;
         node = 0;
         lvl  = 0;
         while (1) begin
            if (!used[node]) begin
               key_mem[node]  = key;
               data_mem[node] = val;
               used[node]     = 1;
               return ST_INSERTED;
            end
            if (lvl >= LEVELS) return ST_ERROR;
            slot = key % 32'(PRIME_TABLE[lvl]);
            nxt  = link_mem[node*SLOTS + slot];
            if (nxt == 0) begin
               if (alloc_count >= NODES) return ST_ERROR;
               nxt = alloc_count;
               alloc_count++;
               used[nxt] = 0;
               for (int s = 0; s < SLOTS; s++) link_mem[nxt*SLOTS + s] = 0;
               link_mem[node*SLOTS + slot] = nxt;
            end
            node = nxt;
            lvl++;
         end
      endfunction

      // index of first used node matching key, or -1
      function int tree_search(logic [31:0] key);
         int unsigned node, lvl, slot;
         node = 0;
         lvl  = 0;
         while (1) begin
            if (used[node] && key_mem[node] == key) return node;
            if (lvl >= LEVELS) return -1;
            slot = key % 32'(PRIME_TABLE[lvl]);
            node = link_mem[node*SLOTS + slot];
            if (node == 0) return -1;
            lvl++;
         end
      endfunction

      function void note_item(logic [1:0] op, logic [31:0] key, logic [31:0] val);
         outcome_type o;
         int hit;
         o.value = '0;
         case (op)
            OP_INSERT: o.status = tree_insert(key, val);
            OP_FIND: begin
               hit = tree_search(key);
               if (hit >= 0) begin
                  o.status = ST_FOUND;
                  o.value  = data_mem[hit];
               end else o.status = ST_NOT_FOUND;
            end
            OP_DELETE: begin
               hit = tree_search(key);
               if (hit >= 0) begin
                  used[hit] = 0;
                  o.status  = ST_DELETED;
               end else o.status = ST_DEL_MISSING;
            end
            default: o.status = ST_NOT_FOUND;
         endcase
         pending.push_back(o);
      endfunction

      function void check_result(logic [2:0] status, logic [31:0] value);
         outcome_type o;
         seen++;
         if (pending.size() == 0) begin
            $error("unexpected result: status %0d found_value %0h", status, value);
            fails++;
            return;
         end
         o = pending.pop_front();
         per_status[o.status]++;
         if (status !== o.status) begin
            $error("status: expected %0d, actual %0d", o.status, status);
            fails++;
         end
         if (value !== o.value) begin
            $error("found_value: expected %0h, actual %0h", o.value, value);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [31:0] req_key;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_found_value;

   tree_scoreboard sb;
   logic [31:0] key_pool [32];
   int          burst_left;
   int unsigned cycles;

   prime_modulus_hash_tree_top #(
      .NODE_COUNT(NODES), .CHILD_SLOTS(SLOTS), .MAX_LEVELS(LEVELS)
   ) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_found_value(rsp_found_value)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_status, rsp_found_value);
   end

   // present one item and hold it until accepted
   task automatic send_item(logic [1:0] op, logic [31:0] key, logic [31:0] val);
      req_opcode <= op;
      req_key    <= key;
      req_value  <= val;
      start      <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(op, key, val);
      // bursts of back-to-back items, then usually a random gap
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   endtask

   task automatic random_item();
      int pick;
      logic [31:0] k;
      pick = $urandom_range(0, 99);
      k    = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 31)];
      if (pick < 45)      send_item(OP_INSERT, k, $urandom);
      else if (pick < 70) send_item(OP_FIND, k, $urandom);
      else if (pick < 92) send_item(OP_DELETE, k, $urandom);
      else                send_item(OP_UNUSED, k, $urandom);
   endtask

   initial begin
      int guard;
      sb = new();
      sb.clear_tree();
      burst_left = 0;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_opcode <= OP_INSERT;
      req_key    <= '0;
      req_value  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, each opcode, reuse of deleted root
      send_item(OP_INSERT, 32'h0, 32'h7fffffff);
      send_item(OP_FIND, 32'h0, 32'hffffffff);
      send_item(OP_FIND, 32'hffffffff, 32'h0);
      send_item(OP_INSERT, 32'hffffffff, 32'h80000000);
      send_item(OP_FIND, 32'hffffffff, 32'h0);
      send_item(OP_DELETE, 32'h0, 32'h0);
      send_item(OP_DELETE, 32'h0, 32'h0);
      send_item(OP_FIND, 32'h0, 32'h0);
      send_item(OP_UNUSED, 32'hffffffff, 32'hffffffff);
      send_item(OP_INSERT, 32'h0, 32'h12345678);
      // duplicates of one key sink a level each until the depth limit
      for (int i = 0; i < 12; i++) send_item(OP_INSERT, 32'd5, 32'(i));
      send_item(OP_FIND, 32'd5, 32'h0);
      send_item(OP_DELETE, 32'd5, 32'h0);
      send_item(OP_FIND, 32'd5, 32'h0);

      // random: mostly keys from a small pool so finds and deletes hit
      foreach (key_pool[i])
         key_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 63);
      for (int i = 0; i < 600; i++) random_item();

      // fill the node pool, then push past it
      guard = 0;
      while (sb.alloc_count < NODES && guard < 2000) begin
         send_item(OP_INSERT, $urandom, $urandom);
         guard++;
      end
      for (int i = 0; i < 40; i++) random_item();
      for (int i = 0; i < 10; i++) send_item(OP_INSERT, $urandom, $urandom);

      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d results: %0d inserted, %0d found, %0d not found, %0d deleted,",
               sb.seen, sb.per_status[ST_INSERTED], sb.per_status[ST_FOUND],
               sb.per_status[ST_NOT_FOUND], sb.per_status[ST_DELETED]);
      $display("%0d delete misses, %0d full-or-deep errors; %0d nodes allocated.",
               sb.per_status[ST_DEL_MISSING], sb.per_status[ST_ERROR], sb.alloc_count);
      if (sb.fails == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
